@@ rtl/rtfp_pkg.sv @@
// Shared types and constants for the receive tuning frequency planner.
// No dependencies; the top level and the testbench refer to it by scoped names.
package rtfp_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SIDE,
      ST_ROW,
      ST_CHECK,
      ST_FINISH
   } state_type;

   // Configuration register indexes.
   localparam logic [3:0] CSR_IF2_TARGET = 4'd0;
   localparam logic [3:0] CSR_INST_BW    = 4'd1;

   localparam logic signed [28:0] IF2_RESET = 29'sd0;
   localparam logic [27:0]        BW_RESET  = 28'd80000000;

   // Frequency plan constants in Hz.
   localparam logic [32:0] RF_MIN           = 33'd10000000;
   localparam logic [32:0] RF_MAX           = 33'd6000000000;
   localparam logic [32:0] BAND_SPLIT       = 33'd1800000000;
   localparam logic [32:0] INJ_SPLIT        = 33'd5100000000;
   localparam logic [32:0] STATIC_LO1_SPLIT = 33'd50000000;
   localparam logic [32:0] PREAMP_SPLIT     = 33'd800000000;
   localparam logic [31:0] IF1_LB           = 32'd2345000000;
   localparam logic [31:0] IF1_HB           = 32'd1250000000;

   // Preselector band edges.
   localparam logic [32:0] LB_EDGE_0 = 33'd500000000;
   localparam logic [32:0] LB_EDGE_1 = 33'd800000000;
   localparam logic [32:0] LB_EDGE_2 = 33'd1200000000;
   localparam logic [32:0] HB_EDGE_0 = 33'd3000000000;
   localparam logic [32:0] HB_EDGE_1 = 33'd4100000000;
   localparam logic [32:0] HB_EDGE_2 = 33'd5100000000;

   localparam logic [1:0] PRESEL_PATH_0 = 2'd0;
   localparam logic [1:0] PRESEL_PATH_1 = 2'd1;
   localparam logic [1:0] PRESEL_PATH_2 = 2'd2;
   localparam logic [1:0] PRESEL_PATH_3 = 2'd3;

endpackage

@@ rtl/rx_tuning_frequency_planner_top.sv @@
// Receive tuning frequency planner: band and preselector choice, LO1 and LO2 plan
// with an iterative mixer spur search. Depends on rtfp_pkg.
//
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_rf_freq_hz
// rsp       out        rsp_valid/rsp_stall   band, preselector paths, LO plan
// csr       in         csr_we                csr_index, csr_wdata
//
// A word passes the setup state, the spur search and the finish state. The search runs
// one harmonic check a cycle on a single shared subtract-and-compare unit, in one
// (order, side) pass after another; a pass ends at the first spur it finds.
// req_stall is high from acceptance until the result is loaded into the output
// register; a stalled result holds there while the next word is already accepted.
// Reset is synchronous; it loads the configuration reset values and clears the held preselector paths.
module rx_tuning_frequency_planner_top #(
   parameter int MAX_ORDER = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [32:0] req_rf_freq_hz,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_highband,
   output logic [1:0]  rsp_lb_presel_path,
   output logic [1:0]  rsp_hb_presel_path,
   output logic        rsp_lb_preamp_presel_on,
   output logic [32:0] rsp_lo1_hz,
   output logic [31:0] rsp_lo2_hz,
   output logic        rsp_lo1_high_side,
   output logic        rsp_lo2_high_side,
   input  logic        csr_we,
   input  logic [3:0]  csr_index,
   input  logic [28:0] csr_wdata
);

   // Width that holds a*lo1 - b*lo2 plus and minus IF2, doubled, with sign.
   localparam int DW = $clog2((MAX_ORDER + 1) * 64'd6400000000) + 3;
   localparam int CW = $clog2(MAX_ORDER + 1);

   rtfp_pkg::state_type state_ff, state_in;

   logic signed [28:0] if2_ff;
   logic [27:0]        bw_ff;
   logic [1:0]         lb_hold_ff, lb_hold_in;
   logic [1:0]         hb_hold_ff, hb_hold_in;

   logic [32:0] rf_ff, rf_in;
   logic        hb_ff, hb_in;
   logic [31:0] if1_ff, if1_in;
   logic [32:0] lo1_ff, lo1_in;
   logic [31:0] lo2_hi_ff, lo2_hi_in;
   logic [31:0] lo2_lo_ff, lo2_lo_in;

   logic signed [DW-1:0] acc_ff, acc_in;
   logic signed [DW-1:0] d_ff, d_in;
   logic [CW-1:0]        ord_ff, ord_in;
   logic [CW-1:0]        a_ff, a_in;
   logic [CW-1:0]        b_ff, b_in;
   logic                 side_hi_ff, side_hi_in;
   logic                 lo2_high_ff, lo2_high_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_hb_ff, out_preamp_ff, out_lo1_hs_ff, out_lo2_hs_ff;
   logic [1:0]  out_lb_ff, out_hb_path_ff;
   logic [32:0] out_lo1_ff;
   logic [31:0] out_lo2_ff;

   logic                 accept;
   logic                 out_load;
   logic [32:0]          rf_clip;
   logic [31:0]          if1_sel;
   logic [33:0]          lo1_wide;
   logic [33:0]          lo2_hi_wide;
   logic [33:0]          lo2_lo_wide;
   logic [31:0]          lo2_side;
   logic [31:0]          lo2_final;
   logic signed [DW-1:0] lo1_ext;
   logic signed [DW-1:0] lo2_ext;
   logic signed [DW-1:0] if2_ext;
   logic signed [DW-1:0] bw_ext;
   logic signed [DW-1:0] e_plus;
   logic signed [DW-1:0] e_minus;
   logic signed [DW-1:0] tw_plus;
   logic signed [DW-1:0] tw_minus;
   logic                 spur_hit;

   assign accept    = req_valid && (state_ff == rtfp_pkg::ST_IDLE);
   assign req_stall = (state_ff != rtfp_pkg::ST_IDLE);
   assign out_load  = (state_ff == rtfp_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // Front end: clip, band, first IF, LO1 and the two LO2 candidates.
   always_comb begin
      priority if (req_rf_freq_hz < rtfp_pkg::RF_MIN) begin
         rf_clip = rtfp_pkg::RF_MIN;
      end else if (req_rf_freq_hz > rtfp_pkg::RF_MAX) begin
         rf_clip = rtfp_pkg::RF_MAX;
      end else begin
         rf_clip = req_rf_freq_hz;
      end
      hb_in   = (rf_ff > rtfp_pkg::BAND_SPLIT);
      if1_sel = hb_in ? rtfp_pkg::IF1_HB : rtfp_pkg::IF1_LB;
      priority if (rf_ff <= rtfp_pkg::STATIC_LO1_SPLIT) begin
         lo1_wide = {2'b00, if1_sel} + {1'b0, rtfp_pkg::STATIC_LO1_SPLIT};
      end else if (rf_ff <= rtfp_pkg::INJ_SPLIT) begin
         lo1_wide = {1'b0, rf_ff} + {2'b00, if1_sel};
      end else begin
         lo1_wide = {1'b0, rf_ff} - {2'b00, if1_sel};
      end
      lo2_hi_wide = {2'b00, if1_sel} + {{5{if2_ff[28]}}, if2_ff};
      lo2_lo_wide = {2'b00, if1_sel} - {{5{if2_ff[28]}}, if2_ff};
      rf_in     = accept ? rf_clip : rf_ff;
      if1_in    = if1_sel;
      lo1_in    = lo1_wide[32:0];
      lo2_hi_in = lo2_hi_wide[31:0];
      lo2_lo_in = lo2_lo_wide[31:0];
   end

   // Preselector choice for the active band; the other band keeps its path.
   always_comb begin
      lb_hold_in = lb_hold_ff;
      hb_hold_in = hb_hold_ff;
      if (state_ff == rtfp_pkg::ST_SETUP) begin
         if (!hb_in) begin
            priority if (rf_ff < rtfp_pkg::LB_EDGE_0) lb_hold_in = rtfp_pkg::PRESEL_PATH_0;
            else if (rf_ff < rtfp_pkg::LB_EDGE_1)     lb_hold_in = rtfp_pkg::PRESEL_PATH_1;
            else if (rf_ff < rtfp_pkg::LB_EDGE_2)     lb_hold_in = rtfp_pkg::PRESEL_PATH_2;
            else                                      lb_hold_in = rtfp_pkg::PRESEL_PATH_3;
         end else begin
            priority if (rf_ff < rtfp_pkg::HB_EDGE_0) hb_hold_in = rtfp_pkg::PRESEL_PATH_0;
            else if (rf_ff < rtfp_pkg::HB_EDGE_1)     hb_hold_in = rtfp_pkg::PRESEL_PATH_1;
            else if (rf_ff < rtfp_pkg::HB_EDGE_2)     hb_hold_in = rtfp_pkg::PRESEL_PATH_2;
            else                                      hb_hold_in = rtfp_pkg::PRESEL_PATH_3;
         end
      end
   end

   // Shared spur check unit: one (a, b) harmonic pair per cycle on the registered d.
   always_comb begin
      lo2_side = side_hi_ff ? lo2_hi_ff : lo2_lo_ff;
      lo1_ext  = {{(DW-33){1'b0}}, lo1_ff};
      lo2_ext  = {{(DW-32){1'b0}}, lo2_side};
      if2_ext  = {{(DW-29){if2_ff[28]}}, if2_ff};
      bw_ext   = {{(DW-28){1'b0}}, bw_ff};
      e_plus   = d_ff + if2_ext;
      e_minus  = d_ff - if2_ext;
      tw_plus  = e_plus <<< 1;
      tw_minus = e_minus <<< 1;
      spur_hit = ((tw_plus < bw_ext) && (tw_plus > -bw_ext))
              || ((tw_minus < bw_ext) && (tw_minus > -bw_ext));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rtfp_pkg::ST_IDLE: begin
            if (accept) state_in = rtfp_pkg::ST_SETUP;
         end
         rtfp_pkg::ST_SETUP: begin
            state_in = rtfp_pkg::ST_SIDE;
         end
         rtfp_pkg::ST_SIDE: begin
            state_in = rtfp_pkg::ST_ROW;
         end
         rtfp_pkg::ST_ROW: begin
            state_in = rtfp_pkg::ST_CHECK;
         end
         rtfp_pkg::ST_CHECK: begin
            priority if (spur_hit) begin
               if (!side_hi_ff && (ord_ff == CW'(1))) state_in = rtfp_pkg::ST_FINISH;
               else                                   state_in = rtfp_pkg::ST_SIDE;
            end else if (b_ff < ord_ff) begin
               state_in = rtfp_pkg::ST_CHECK;
            end else if (a_ff < ord_ff) begin
               state_in = rtfp_pkg::ST_ROW;
            end else begin
               state_in = rtfp_pkg::ST_FINISH;
            end
         end
         rtfp_pkg::ST_FINISH: begin
            if (out_load) state_in = rtfp_pkg::ST_IDLE;
         end
         default: state_in = rtfp_pkg::ST_IDLE;
      endcase
   end

   // Sequencer datapath controls.
   always_comb begin
      acc_in      = acc_ff;
      d_in        = d_ff;
      ord_in      = ord_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      side_hi_in  = side_hi_ff;
      lo2_high_in = lo2_high_ff;
      unique case (state_ff)
         rtfp_pkg::ST_SETUP: begin
            ord_in      = CW'(MAX_ORDER);
            side_hi_in  = 1'b1;
            lo2_high_in = 1'b1;
         end
         rtfp_pkg::ST_SIDE: begin
            // acc runs one row ahead: it holds (a+1)*lo1 while row a is checked.
            acc_in = lo1_ext;
            a_in   = CW'(0);
         end
         rtfp_pkg::ST_ROW: begin
            d_in   = acc_ff - lo2_ext;
            acc_in = acc_ff + lo1_ext;
            a_in   = a_ff + CW'(1);
            b_in   = CW'(1);
         end
         rtfp_pkg::ST_CHECK: begin
            priority if (spur_hit) begin
               if (side_hi_ff) begin
                  side_hi_in = 1'b0;
               end else if (ord_ff == CW'(1)) begin
                  lo2_high_in = 1'b1;
               end else begin
                  ord_in     = ord_ff - CW'(1);
                  side_hi_in = 1'b1;
               end
            end else if (b_ff < ord_ff) begin
               b_in = b_ff + CW'(1);
               d_in = d_ff - lo2_ext;
            end else if (a_ff < ord_ff) begin
               b_in = b_ff;
            end else begin
               lo2_high_in = side_hi_ff;
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   assign lo2_final = lo2_high_ff ? lo2_hi_ff : lo2_lo_ff;

   always_comb begin
      priority if (out_load)   rsp_valid_in = 1'b1;
      else if (rsp_stall)      rsp_valid_in = rsp_valid_ff;
      else                     rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtfp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         if2_ff       <= rtfp_pkg::IF2_RESET;
         bw_ff        <= rtfp_pkg::BW_RESET;
         lb_hold_ff   <= rtfp_pkg::PRESEL_PATH_0;
         hb_hold_ff   <= rtfp_pkg::PRESEL_PATH_0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lb_hold_ff   <= lb_hold_in;
         hb_hold_ff   <= hb_hold_in;
         if (csr_we && (csr_index == rtfp_pkg::CSR_IF2_TARGET)) if2_ff <= csr_wdata;
         if (csr_we && (csr_index == rtfp_pkg::CSR_INST_BW))    bw_ff  <= csr_wdata[27:0];
      end
   end

   always_ff @(posedge clock) begin
      rf_ff       <= rf_in;
      acc_ff      <= acc_in;
      d_ff        <= d_in;
      ord_ff      <= ord_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      side_hi_ff  <= side_hi_in;
      lo2_high_ff <= lo2_high_in;
      if (state_ff == rtfp_pkg::ST_SETUP) begin
         hb_ff     <= hb_in;
         if1_ff    <= if1_in;
         lo1_ff    <= lo1_in;
         lo2_hi_ff <= lo2_hi_in;
         lo2_lo_ff <= lo2_lo_in;
      end
      if (out_load) begin
         out_hb_ff      <= hb_ff;
         out_lb_ff      <= lb_hold_ff;
         out_hb_path_ff <= hb_hold_ff;
         out_preamp_ff  <= (rf_ff > rtfp_pkg::PREAMP_SPLIT);
         out_lo1_ff     <= lo1_ff;
         out_lo2_ff     <= lo2_final;
         out_lo1_hs_ff  <= (lo1_ff > rf_ff);
         out_lo2_hs_ff  <= (lo2_final > if1_ff);
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_highband            = out_hb_ff;
   assign rsp_lb_presel_path      = out_lb_ff;
   assign rsp_hb_presel_path      = out_hb_path_ff;
   assign rsp_lb_preamp_presel_on = out_preamp_ff;
   assign rsp_lo1_hz              = out_lo1_ff;
   assign rsp_lo2_hz              = out_lo2_ff;
   assign rsp_lo1_high_side       = out_lo1_hs_ff;
   assign rsp_lo2_high_side       = out_lo2_hs_ff;

endmodule

@@ rtl/rtfp_checker.sv @@
// Port-level checker for the receive tuning frequency planner, bound to the top level.
// Depends only on the top level's ports.
module rtfp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_highband,
   input logic rsp_lb_preamp_presel_on,
   input logic rsp_lo1_high_side
);

   // A result word that is stalled stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // The planner works on one word at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted during search");

   // High band lies above the preamp preselector split.
   a_band_preamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_highband |-> rsp_lb_preamp_presel_on)
      else $error("high band word without preamp preselector");

   // Low-side LO1 injection is only used in the high band.
   a_low_side_band: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_lo1_high_side |-> rsp_highband)
      else $error("low-side LO1 reported in low band");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind rx_tuning_frequency_planner_top rtfp_checker u_rtfp_checker (
   .clock                   (clock),
   .reset                   (reset),
   .req_valid               (req_valid),
   .req_stall               (req_stall),
   .rsp_valid               (rsp_valid),
   .rsp_stall               (rsp_stall),
   .rsp_highband            (rsp_highband),
   .rsp_lb_preamp_presel_on (rsp_lb_preamp_presel_on),
   .rsp_lo1_high_side       (rsp_lo1_high_side)
);

@@ tb/tb_rx_tuning_frequency_planner_top.sv @@
// Self-checking testbench for rx_tuning_frequency_planner_top: directed band edges, then
// random tuning words under several register settings with random idling on both sides.
// Depends on rtfp_pkg and the planner RTL only.
module tb_rx_tuning_frequency_planner_top;

   localparam int HARMONIC_ORDER  = 5;
   localparam int WORST_LATENCY   = 160;
   localparam int QUIET_LIMIT     = 5000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_COUNT     = 8;
   localparam int WORDS_PER_PHASE = 122;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [3:0] CSR_LAST_INDEX = 4'hF;

   localparam longint RF_MIN_HZ      = 64'sd10_000_000;
   localparam longint RF_MAX_HZ      = 64'sd6_000_000_000;
   localparam longint BAND_SPLIT_HZ  = 64'sd1_800_000_000;
   localparam longint INJ_SPLIT_HZ   = 64'sd5_100_000_000;
   localparam longint STATIC_LO1_HZ  = 64'sd50_000_000;
   localparam longint PREAMP_EDGE_HZ = 64'sd800_000_000;
   localparam longint IF1_LB_HZ      = 64'sd2_345_000_000;
   localparam longint IF1_HB_HZ      = 64'sd1_250_000_000;

   localparam longint BAND_EDGES [10] = '{
      64'sd10_000_000, 64'sd50_000_000, 64'sd500_000_000, 64'sd800_000_000,
      64'sd1_200_000_000, 64'sd1_800_000_000, 64'sd3_000_000_000,
      64'sd4_100_000_000, 64'sd5_100_000_000, 64'sd6_000_000_000
   };

   localparam logic [32:0] CORNER_WORDS [23] = '{
      33'd0, 33'd9_999_999, 33'd10_000_000, 33'd10_000_001, 33'd50_000_000,
      33'd50_000_001, 33'd499_999_999, 33'd500_000_000, 33'd799_999_999,
      33'd800_000_000, 33'd800_000_001, 33'd1_199_999_999, 33'd1_200_000_000,
      33'd1_800_000_000, 33'd1_800_000_001, 33'd2_999_999_999, 33'd3_000_000_000,
      33'd4_100_000_000, 33'd5_100_000_000, 33'd5_100_000_001, 33'd6_000_000_000,
      33'd6_000_000_001, 33'h1_FFFF_FFFF
   };

   typedef struct {
      logic        highband;
      logic [1:0]  lb_presel_path;
      logic [1:0]  hb_presel_path;
      logic        lb_preamp_presel_on;
      logic [32:0] lo1_hz;
      logic [31:0] lo2_hz;
      logic        lo1_high_side;
      logic        lo2_high_side;
   } tuning_plan_type;

   class tuning_plan_board;
      tuning_plan_type plans [$];
      longint          if2_hz;
      longint          bw_hz;
      logic [1:0]      lb_hold;
      logic [1:0]      hb_hold;
      int              failures;
      int              planned;
      int              high_band_words;
      int              low_side_lo2;

      function new();
         if2_hz          = 0;
         bw_hz           = 64'sd80_000_000;
         lb_hold         = rtfp_pkg::PRESEL_PATH_0;
         hb_hold         = rtfp_pkg::PRESEL_PATH_0;
         failures        = 0;
         planned         = 0;
         high_band_words = 0;
         low_side_lo2    = 0;
      endfunction

      function void write_register(logic [3:0] index, logic [28:0] data);
         if (index == rtfp_pkg::CSR_IF2_TARGET) begin
            if2_hz = longint'($signed(data));
         end else if (index == rtfp_pkg::CSR_INST_BW) begin
            bw_hz = longint'({36'd0, data[27:0]});
         end
      endfunction

      // A side is spurious when some a*LO1 - b*LO2 product lands within half the
      // bandwidth of either image of the second IF.
      function bit has_spur(longint lo1, longint lo2, int order);
         longint d;
         longint up;
         longint down;
         for (int a = 1; a <= order; a++) begin
            for (int b = 1; b <= order; b++) begin
               d    = a * lo1 - b * lo2;
               up   = d + if2_hz;
               down = d - if2_hz;
               if (up < 0) up = -up;
               if (down < 0) down = -down;
               if (2 * up < bw_hz || 2 * down < bw_hz) return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_request(logic [32:0] raw);
         longint          rf;
         longint          if1;
         longint          lo1;
         longint          lo2;
         bit              hb;
         bit              lo2_high;
         tuning_plan_type plan;
         rf = longint'({31'd0, raw});
         if (rf < RF_MIN_HZ) rf = RF_MIN_HZ;
         if (rf > RF_MAX_HZ) rf = RF_MAX_HZ;
         hb = rf > BAND_SPLIT_HZ;
         if (!hb) begin
            if (rf < 64'sd500_000_000) lb_hold = rtfp_pkg::PRESEL_PATH_0;
            else if (rf < 64'sd800_000_000) lb_hold = rtfp_pkg::PRESEL_PATH_1;
            else if (rf < 64'sd1_200_000_000) lb_hold = rtfp_pkg::PRESEL_PATH_2;
            else lb_hold = rtfp_pkg::PRESEL_PATH_3;
         end else begin
            if (rf < 64'sd3_000_000_000) hb_hold = rtfp_pkg::PRESEL_PATH_0;
            else if (rf < 64'sd4_100_000_000) hb_hold = rtfp_pkg::PRESEL_PATH_1;
            else if (rf < 64'sd5_100_000_000) hb_hold = rtfp_pkg::PRESEL_PATH_2;
            else hb_hold = rtfp_pkg::PRESEL_PATH_3;
         end
         if1 = hb ? IF1_HB_HZ : IF1_LB_HZ;
         if (rf <= STATIC_LO1_HZ) lo1 = if1 + STATIC_LO1_HZ;
         else if (rf <= INJ_SPLIT_HZ) lo1 = rf + if1;
         else lo1 = rf - if1;
         // High side wins by default when every order shows spurs on both sides.
         lo2_high = 1'b1;
         for (int ord = HARMONIC_ORDER; ord >= 1; ord--) begin
            if (!has_spur(lo1, if1 + if2_hz, ord)) begin
               lo2_high = 1'b1;
               break;
            end
            if (!has_spur(lo1, if1 - if2_hz, ord)) begin
               lo2_high = 1'b0;
               break;
            end
         end
         lo2 = lo2_high ? if1 + if2_hz : if1 - if2_hz;
         plan.highband            = hb;
         plan.lb_presel_path      = lb_hold;
         plan.hb_presel_path      = hb_hold;
         plan.lb_preamp_presel_on = rf > PREAMP_EDGE_HZ;
         plan.lo1_hz              = lo1[32:0];
         plan.lo2_hz              = lo2[31:0];
         plan.lo1_high_side       = lo1 > rf;
         plan.lo2_high_side       = lo2 > if1;
         plans.push_back(plan);
         planned++;
         if (hb) high_band_words++;
         if (!lo2_high) low_side_lo2++;
      endfunction

      function void check_plan(tuning_plan_type got);
         tuning_plan_type want;
         if (plans.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: result word with nothing expected, lo1=%0d lo2=%0d",
                        $realtime, got.lo1_hz, got.lo2_hz);
            return;
         end
         want = plans.pop_front();
         if (got.highband !== want.highband || got.lb_presel_path !== want.lb_presel_path ||
             got.hb_presel_path !== want.hb_presel_path ||
             got.lb_preamp_presel_on !== want.lb_preamp_presel_on ||
             got.lo1_hz !== want.lo1_hz || got.lo2_hz !== want.lo2_hz ||
             got.lo1_high_side !== want.lo1_high_side ||
             got.lo2_high_side !== want.lo2_high_side) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("%0t: plan mismatch (hb lb hbp preamp lo1 lo2 side1 side2)", $realtime);
               $display("   expected %0d %0d %0d %0d %0d %0d %0d %0d", want.highband,
                        want.lb_presel_path, want.hb_presel_path, want.lb_preamp_presel_on,
                        want.lo1_hz, want.lo2_hz, want.lo1_high_side, want.lo2_high_side);
               $display("   actual   %0d %0d %0d %0d %0d %0d %0d %0d", got.highband,
                        got.lb_presel_path, got.hb_presel_path, got.lb_preamp_presel_on,
                        got.lo1_hz, got.lo2_hz, got.lo1_high_side, got.lo2_high_side);
            end
         end
      endfunction

      function int pending();
         return plans.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [32:0] req_rf_freq_hz;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_highband;
   logic [1:0]  rsp_lb_presel_path;
   logic [1:0]  rsp_hb_presel_path;
   logic        rsp_lb_preamp_presel_on;
   logic [32:0] rsp_lo1_hz;
   logic [31:0] rsp_lo2_hz;
   logic        rsp_lo1_high_side;
   logic        rsp_lo2_high_side;
   logic        csr_we;
   logic [3:0]  csr_index;
   logic [28:0] csr_wdata;

   tuning_plan_board board;
   tuning_plan_type  seen_plan;
   int               sender_idle_pct;
   int               receiver_idle_pct;
   bit               hold_off_request;

   rx_tuning_frequency_planner_top #(
      .MAX_ORDER(HARMONIC_ORDER)
   ) dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_rf_freq_hz          (req_rf_freq_hz),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_highband            (rsp_highband),
      .rsp_lb_presel_path      (rsp_lb_presel_path),
      .rsp_hb_presel_path      (rsp_hb_presel_path),
      .rsp_lb_preamp_presel_on (rsp_lb_preamp_presel_on),
      .rsp_lo1_hz              (rsp_lo1_hz),
      .rsp_lo2_hz              (rsp_lo2_hz),
      .rsp_lo1_high_side       (rsp_lo1_high_side),
      .rsp_lo2_high_side       (rsp_lo2_high_side),
      .csr_we                  (csr_we),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Every handshake is sampled at the edge, so the register mirror and the
   // expected plans follow exactly what the block saw.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) board.write_register(csr_index, csr_wdata);
         if (req_valid && !req_stall) board.note_request(req_rf_freq_hz);
         if (rsp_valid && !rsp_stall) begin
            seen_plan.highband            = rsp_highband;
            seen_plan.lb_presel_path      = rsp_lb_presel_path;
            seen_plan.hb_presel_path      = rsp_hb_presel_path;
            seen_plan.lb_preamp_presel_on = rsp_lb_preamp_presel_on;
            seen_plan.lo1_hz              = rsp_lo1_hz;
            seen_plan.lo2_hz              = rsp_lo2_hz;
            seen_plan.lo1_high_side       = rsp_lo1_high_side;
            seen_plan.lo2_high_side       = rsp_lo2_high_side;
            board.check_plan(seen_plan);
         end
      end
   end

   initial begin : result_sink
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no word moved for %0d cycles", $realtime, QUIET_LIMIT);
      $display("tb_rx_tuning_frequency_planner_top failed");
      $finish;
   end

   task automatic send_word(input logic [32:0] rf);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_rf_freq_hz <= rf;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_csr(input logic [3:0] index, input logic [28:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // The last word was accepted at the current edge, so step an edge first to be
   // sure the scoreboard has noted it before the queue is polled.
   task automatic wait_drained();
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Mostly in-range requests, with a share near the band and filter edges, some in and
   // just above the static LO1 region and the rest anywhere in the 33-bit field.
   function automatic logic [32:0] pick_rf();
      logic [63:0] wide;
      int unsigned roll;
      wide = {$urandom, $urandom};
      roll = $urandom_range(99);
      if (roll < 60) return 33'(RF_MIN_HZ + longint'(wide % 64'(RF_MAX_HZ - RF_MIN_HZ + 1)));
      if (roll < 70) return 33'(wide % 64'd60_000_000);
      if (roll < 85)
         return 33'(BAND_EDGES[$urandom_range(9)] + longint'($urandom_range(6)) - 64'sd3);
      return wide[32:0];
   endfunction

   initial begin : stimulus
      int          phase;
      int          if2_value;
      int          bw_value;
      logic [28:0] if2_word;
      logic [28:0] bw_word;
      int          leftover;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_rf_freq_hz    <= '0;
      csr_we            <= 1'b0;
      csr_index         <= rtfp_pkg::CSR_IF2_TARGET;
      csr_wdata         <= '0;
      sender_idle_pct   = 15;
      receiver_idle_pct = 77;
      hold_off_request  = 1'b0;
      board             = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (CORNER_WORDS[i]) send_word(CORNER_WORDS[i]);
      req_valid <= 1'b0;
      wait_drained();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         sender_idle_pct   = phase < 3 ? 15 : (phase < 6 ? 77 : 0);
         receiver_idle_pct = phase < 3 ? 77 : (phase < 6 ? 15 : 0);
         case (phase)
            0: begin
               if2_value = -200_000_000;
               bw_value  = 80_000_000;
            end
            1: begin
               if2_value = -268_435_456;
               bw_value  = 0;
            end
            2: begin
               if2_value = 268_435_455;
               bw_value  = 268_435_455;
            end
            3: begin
               if2_value = 200_000_000;
               bw_value  = 200_000_000;
            end
            default: begin
               if2_value = int'($urandom_range(400_000_000)) - 200_000_000;
               bw_value  = int'($urandom_range(200_000_000));
            end
         endcase
         if2_word = 29'(if2_value);
         // The top bit of the bandwidth write lies outside the register and must be dropped.
         bw_word  = {1'($urandom_range(1)), 28'(bw_value)};
         write_csr(rtfp_pkg::CSR_IF2_TARGET, if2_word);
         write_csr(rtfp_pkg::CSR_INST_BW, bw_word);
         write_csr(4'($urandom_range(CSR_LAST_INDEX, rtfp_pkg::CSR_INST_BW + 1)),
                   29'({$urandom, $urandom}));
         csr_we <= 1'b0;
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            if (i == 10 && (phase == 1 || phase == 6)) hold_off_request = 1'b1;
            send_word(pick_rf());
         end
         req_valid <= 1'b0;
         wait_drained();
      end

      repeat (WORST_LATENCY) @(posedge clock);
      leftover = board.pending();
      if (leftover != 0) $display("%0d expected plan words never arrived", leftover);
      $display("Planned %0d tuning words over %0d register settings with random idling.",
               board.planned, PHASE_COUNT + 1);
      $display("%0d words fell in the high band and %0d took a low-side second LO.",
               board.high_band_words, board.low_side_lo2);
      if (board.failures == 0 && leftover == 0) begin
         $display("tb_rx_tuning_frequency_planner_top passed");
      end else begin
         $display("%0d mismatches", board.failures);
         $display("tb_rx_tuning_frequency_planner_top failed");
      end
      $finish;
   end

endmodule
